/* rtl/core/rsd_pkg.sv */
// shared types, codes and transition tables for the rotary encoder step decoder
package rsd_pkg;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_PUSH = 2'd1,
    ACT_CW   = 2'd2,
    ACT_CCW  = 2'd3
  } action_t;

  typedef struct packed {
    logic              last_a;
    logic              last_b;
    logic signed [3:0] step_count;
  } enc_state_t;

  localparam logic MODE_THREE = 1'b0;
  localparam logic MODE_FOUR  = 1'b1;

  localparam logic signed [3:0] THRESH_THREE = 4'sd3;
  localparam logic signed [3:0] THRESH_FOUR  = 4'sd4;

  // index is {last_a, last_b, phase_a, phase_b}
  localparam logic signed [1:0] STEP_THREE [16] = '{
    2'sd0,  2'sd1,  2'sd0,  -2'sd1,
    -2'sd1, 2'sd0,  2'sd0,  2'sd1,
    2'sd0,  2'sd0,  2'sd0,  2'sd0,
    2'sd1,  -2'sd1, 2'sd0,  2'sd0
  };

  localparam logic signed [1:0] STEP_FOUR [16] = '{
    2'sd0,  -2'sd1, 2'sd1,  2'sd0,
    2'sd1,  2'sd0,  2'sd0,  -2'sd1,
    -2'sd1, 2'sd0,  2'sd0,  2'sd1,
    2'sd0,  2'sd1,  -2'sd1, 2'sd0
  };

endpackage

/* rtl/core/rotary_encoder_step_decoder.sv */
// rotary encoder step decoder: sample register, decode, result register
// items pass the sample register, then the result register
// throughput: one item per cycle unless stalled; the input register drains as the result frees
// a stalled result holds off at most one more item in the input register
// reset empties both registers, clears the phase history and the step counter; mode resets to 4-phase
module rotary_encoder_step_decoder (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             encoder_mode,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             phase_a,
  input  logic             phase_b,
  input  logic             switch_pressed,
  output logic             out_valid,
  input  logic             out_ready,
  output rsd_pkg::action_t action
);
  import rsd_pkg::*;

  logic       mode;
  logic       s1_valid;
  logic       s1_a;
  logic       s1_b;
  logic       s1_sw;
  enc_state_t enc_state;
  enc_state_t enc_state_next;
  action_t    action_next;
  logic       s1_advance;

  assign cfg_ready  = 1'b1;
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  rsd_decode u_decode (
    .phase_a        (s1_a),
    .phase_b        (s1_b),
    .switch_pressed (s1_sw),
    .mode           (mode),
    .state_cur      (enc_state),
    .action         (action_next),
    .state_next     (enc_state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_FOUR;
    end else if (cfg_valid && cfg_ready) begin
      mode <= encoder_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_a  <= phase_a;
      s1_b  <= phase_b;
      s1_sw <= switch_pressed;
    end
  end

  // history and counter move only when an item leaves the sample register
  always_ff @(posedge clk) begin
    if (rst) begin
      enc_state <= '0;
    end else if (s1_advance) begin
      enc_state <= enc_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      action <= action_next;
    end
  end

endmodule

/* rtl/core/rsd_decode.sv */
// push detection, transition decode, step accumulation and detent detection for one sample
module rsd_decode (
  input  logic                phase_a,
  input  logic                phase_b,
  input  logic                switch_pressed,
  input  logic                mode,
  input  rsd_pkg::enc_state_t state_cur,
  output rsd_pkg::action_t    action,
  output rsd_pkg::enc_state_t state_next
);
  import rsd_pkg::*;

  logic [3:0]        key;
  logic signed [1:0] delta;
  logic signed [3:0] sum;
  logic signed [3:0] thr;
  logic signed [3:0] neg_thr;

  assign key     = {state_cur.last_a, state_cur.last_b, phase_a, phase_b};
  assign delta   = (mode == MODE_FOUR) ? STEP_FOUR[key] : STEP_THREE[key];
  assign sum     = state_cur.step_count + {{2{delta[1]}}, delta};
  assign thr     = (mode == MODE_FOUR) ? THRESH_FOUR : THRESH_THREE;
  assign neg_thr = -thr;

  always_comb begin
    action     = ACT_NONE;
    state_next = state_cur;
    priority if (switch_pressed) begin
      action = ACT_PUSH;
    end else if (phase_a == state_cur.last_a && phase_b == state_cur.last_b) begin
      action = ACT_NONE;
    end else begin
      state_next.last_a = phase_a;
      state_next.last_b = phase_b;
      // sum stays within -4..4, so the 4-bit compare is safe
      priority if (sum <= neg_thr) begin
        action                = ACT_CCW;
        state_next.step_count = 4'sd0;
      end else if (sum >= thr) begin
        action                = ACT_CW;
        state_next.step_count = 4'sd0;
      end else begin
        state_next.step_count = sum;
      end
    end
  end

endmodule

/* rtl/core/rsd_checker.sv */
// port-level checks for the rotary encoder step decoder, bound to the top level
module rsd_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             switch_pressed,
  input logic             out_valid,
  input logic             out_ready,
  input rsd_pkg::action_t action
);
  import rsd_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(action))
    else $error("stalled result dropped or changed");

  // input stalls only when both registers hold items and the output is stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // a press item held in the sample register reaches the output as a push result if the output drains
  a_push_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && switch_pressed) ##1 (!out_valid || out_ready)
    |=> out_valid && action == ACT_PUSH)
    else $error("press item did not give a push result");

endmodule

bind rotary_encoder_step_decoder rsd_checker u_rsd_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .switch_pressed (switch_pressed),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .action         (action)
);
